// ===== src/utf7e_pkg.sv =====
// Package for the UTF-7 encoder: beat types, encoder state and the
// per-unit encoding functions. No dependencies.
package utf7e_pkg;

  localparam int unsigned MaxBytes = 6;
  localparam int unsigned UnitBytes = 3;

  localparam logic [7:0] ChPlus  = 8'h2B;
  localparam logic [7:0] ChMinus = 8'h2D;
  localparam logic [7:0] ChNull  = 8'h00;

  localparam logic [20:0] MaxScalar  = 21'h10FFFF;
  localparam logic [20:0] MaxBmp     = 21'h00FFFF;
  localparam logic [20:0] SuppOffset = 21'h010000;
  localparam logic [5:0]  HiSurr     = 6'b110110;
  localparam logic [5:0]  LoSurr     = 6'b110111;

  localparam logic CmdEncode = 1'b0;
  localparam logic CmdEnd    = 1'b1;

  localparam logic [1:0] PhaseNone = 2'd0;
  localparam logic [1:0] PhaseTwo  = 2'd1;
  localparam logic [1:0] PhaseFour = 2'd2;

  typedef struct packed {
    logic        command;
    logic [20:0] code_point;
  } utf7e_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       last;
    logic       error;
  } utf7e_out_t;

  typedef struct packed {
    logic       in_base64;
    logic [1:0] phase;
    logic [5:0] carry_bits;
  } utf7e_state_t;

  typedef struct packed {
    logic [UnitBytes-1:0][7:0] bytes;
    logic [1:0]                count;
    utf7e_state_t              nxt;
  } utf7e_unit_t;

  typedef struct packed {
    logic [MaxBytes-1:0][7:0] bytes;
    logic [2:0]               count;
    logic                     error;
  } utf7e_burst_t;

  function automatic logic strict_direct(input logic [15:0] u);
    return u inside {16'd9, 16'd10, 16'd13, 16'd32, 16'd39, 16'd40, 16'd41,
                     16'd44, 16'd45, 16'd46, [16'd48:16'd58], 16'd63,
                     [16'd65:16'd90], [16'd97:16'd122]};
  endfunction

  function automatic logic [7:0] sextet_char(input logic [5:0] v);
    logic [7:0] w;
    w = {2'b00, v};
    if (v < 6'd26) begin
      return 8'h41 + w;
    end else if (v < 6'd52) begin
      return 8'h61 + w - 8'd26;
    end else if (v < 6'd62) begin
      return 8'h30 + w - 8'd52;
    end else if (v == 6'd62) begin
      return ChPlus;
    end else begin
      return 8'h2F;
    end
  endfunction

  // Encodes one 16-bit unit; bytes[0] goes out first.
  function automatic utf7e_unit_t encode_unit(input utf7e_state_t st,
                                              input logic [15:0] u);
    utf7e_unit_t r;
    r = '0;
    r.nxt = st;
    if (st.in_base64) begin
      if (strict_direct(u)) begin
        if (st.phase != PhaseNone) begin
          r.bytes[0] = sextet_char(st.carry_bits);
          r.bytes[1] = ChMinus;
          r.bytes[2] = u[7:0];
          r.count = 2'd3;
        end else begin
          r.bytes[0] = ChMinus;
          r.bytes[1] = u[7:0];
          r.count = 2'd2;
        end
        r.nxt.in_base64 = 1'b0;
      end else if (st.phase == PhaseTwo) begin
        r.bytes[0] = sextet_char(st.carry_bits | {2'b00, u[15:12]});
        r.bytes[1] = sextet_char(u[11:6]);
        r.bytes[2] = sextet_char(u[5:0]);
        r.count = 2'd3;
        r.nxt.phase = PhaseNone;
      end else if (st.phase == PhaseFour) begin
        r.bytes[0] = sextet_char(st.carry_bits | {4'b0000, u[15:14]});
        r.bytes[1] = sextet_char(u[13:8]);
        r.bytes[2] = sextet_char(u[7:2]);
        r.count = 2'd3;
        r.nxt.carry_bits = {u[1:0], 4'b0000};
        r.nxt.phase = PhaseTwo;
      end else begin
        r.bytes[0] = sextet_char(u[15:10]);
        r.bytes[1] = sextet_char(u[9:4]);
        r.count = 2'd2;
        r.nxt.carry_bits = {u[3:0], 2'b00};
        r.nxt.phase = PhaseFour;
      end
    end else begin
      if (strict_direct(u)) begin
        r.bytes[0] = u[7:0];
        r.count = 2'd1;
      end else if (u == {8'h00, ChPlus}) begin
        r.bytes[0] = ChPlus;
        r.bytes[1] = ChMinus;
        r.count = 2'd2;
      end else begin
        r.bytes[0] = ChPlus;
        r.bytes[1] = sextet_char(u[15:10]);
        r.bytes[2] = sextet_char(u[9:4]);
        r.count = 2'd3;
        r.nxt.carry_bits = {u[3:0], 2'b00};
        r.nxt.phase = PhaseFour;
        r.nxt.in_base64 = 1'b1;
      end
    end
    return r;
  endfunction

endpackage

// ===== src/utf7e_encode.sv =====
// Encoder core: shift state registers and the combinational expansion of one
// item into a burst of up to six bytes. Depends on utf7e_pkg.
module utf7e_encode import utf7e_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  utf7e_in_t    item_i,
  input  logic         commit_i,
  output utf7e_burst_t burst_o
);

  utf7e_state_t state_d, state_q;
  utf7e_unit_t  first, second;
  logic [20:0]  offs;
  logic [2:0]   j;

  assign offs = item_i.code_point - SuppOffset;

  always_comb begin
    burst_o = '0;
    state_d = state_q;
    first   = '0;
    second  = '0;
    j       = '0;
    if (item_i.command == CmdEnd) begin
      if (state_q.in_base64) begin
        if (state_q.phase != PhaseNone) begin
          burst_o.bytes[0] = sextet_char(state_q.carry_bits);
          burst_o.bytes[1] = ChMinus;
          burst_o.count = 3'd2;
        end else begin
          burst_o.bytes[0] = ChMinus;
          burst_o.count = 3'd1;
        end
        state_d.in_base64 = 1'b0;
      end
    end else if (item_i.code_point > MaxScalar) begin
      burst_o.bytes[0] = ChNull;
      burst_o.count = 3'd1;
      burst_o.error = 1'b1;
    end else if (item_i.code_point > MaxBmp) begin
      // Supplementary plane: high surrogate then low surrogate.
      first  = encode_unit(state_q, {HiSurr, offs[19:10]});
      second = encode_unit(first.nxt, {LoSurr, offs[9:0]});
      for (int i = 0; i < MaxBytes; i++) begin
        j = 3'(i) - {1'b0, first.count};
        if (3'(i) < {1'b0, first.count}) begin
          burst_o.bytes[i] = first.bytes[i[1:0]];
        end else if (j < {1'b0, second.count}) begin
          burst_o.bytes[i] = second.bytes[j[1:0]];
        end
      end
      burst_o.count = {1'b0, first.count} + {1'b0, second.count};
      state_d = second.nxt;
    end else begin
      first = encode_unit(state_q, item_i.code_point[15:0]);
      burst_o.bytes[UnitBytes-1:0] = first.bytes;
      burst_o.count = {1'b0, first.count};
      state_d = first.nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= '0;
    end else if (commit_i) begin
      state_q <= state_d;
    end
  end

endmodule

// ===== src/utf7e_obuf.sv =====
// Result buffer: holds one burst of bytes and drains it one beat a cycle while
// the output is not stalled. Depends on utf7e_pkg.
module utf7e_obuf import utf7e_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         load_i,
  input  utf7e_burst_t burst_i,
  output logic         free_o,
  output logic         out_valid_o,
  input  logic         out_stall_i,
  output utf7e_out_t   out_data_o
);

  logic [MaxBytes-1:0][7:0] bytes_q;
  logic [2:0]               rem_q;
  logic                     err_q;
  logic                     pop;

  assign out_valid_o         = (rem_q != 3'd0);
  assign pop                 = out_valid_o && !out_stall_i;
  assign out_data_o.out_byte = bytes_q[0];
  assign out_data_o.last     = (rem_q == 3'd1);
  assign out_data_o.error    = err_q;
  // A new burst may enter when the buffer is empty or its final beat leaves now.
  assign free_o = (rem_q == 3'd0) || ((rem_q == 3'd1) && pop);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
    end else if (load_i) begin
      rem_q <= burst_i.count;
    end else if (pop) begin
      rem_q <= rem_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      bytes_q <= burst_i.bytes;
      err_q   <= burst_i.error;
    end else if (pop) begin
      bytes_q <= {8'h00, bytes_q[MaxBytes-1:1]};
    end
  end

endmodule

// ===== src/utf7_encoder.sv =====
// UTF-7 encoder top level: input register, encoder core and result buffer.
// An accepted item waits in the input register, is expanded combinationally by
// the encoder core and is loaded into the result buffer once that is free.
// Throughput: one byte per cycle while the output is not stalled; an item makes
// 0 to 6 bytes, all drained through the single output byte port.
// Reset clears the shift state (no run open) and empties both stages.
// Depends on utf7e_pkg, utf7e_encode and utf7e_obuf.
module utf7_encoder import utf7e_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  utf7e_in_t  in_data_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output utf7e_out_t out_data_o
);

  utf7e_in_t    item_q;
  logic         item_v_q;
  logic         free;
  logic         load;
  utf7e_burst_t burst;

  assign load       = item_v_q && free;
  assign in_stall_o = item_v_q && !free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_v_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      item_v_q <= 1'b1;
    end else if (load) begin
      item_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      item_q <= in_data_i;
    end
  end

  utf7e_encode u_encode (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (item_q),
    .commit_i (load),
    .burst_o  (burst)
  );

  utf7e_obuf u_obuf (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (load),
    .burst_i     (burst),
    .free_o      (free),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== dv/utf7_checker.sv =====
`timescale 1ns / 100ps
// Scoreboard for the UTF-7 encoder. It watches both beat channels, predicts the
// output bytes of every accepted item and compares them in order.
// Depends on utf7e_pkg for the beat types and the command codes.
module utf7_checker import utf7e_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_stall_i,
  input  utf7e_in_t  in_data_i,
  input  logic       out_valid_i,
  input  logic       out_stall_i,
  input  utf7e_out_t out_data_i,
  output int         fail_count_o,
  output int         pending_o
);

  localparam logic [0:63][7:0] Base64Alphabet =
    "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

  localparam logic [20:0] LastScalar = 21'h10FFFF;
  localparam logic [20:0] LastBmp    = 21'h00FFFF;
  localparam logic [20:0] PlaneOne   = 21'h010000;
  localparam logic [5:0]  HighSurrogateTag = 6'b110110;
  localparam logic [5:0]  LowSurrogateTag  = 6'b110111;

  localparam logic [7:0] AsciiPlus  = 8'h2B;
  localparam logic [7:0] AsciiMinus = 8'h2D;

  // Number of bits still waiting for the next sextet.
  localparam logic [1:0] NoBitsHeld   = 2'd0;
  localparam logic [1:0] TwoBitsHeld  = 2'd1;
  localparam logic [1:0] FourBitsHeld = 2'd2;

  // Shadow copy of the encoder's shift state.
  logic       shifted;
  logic [1:0] held_count;
  logic [5:0] held_bits;

  logic [7:0] item_bytes[$];
  utf7e_out_t expected_bytes[$];
  int         fails;

  function automatic logic is_direct(input logic [15:0] u);
    if (u == 16'd9 || u == 16'd10 || u == 16'd13 || u == 16'd32) return 1'b1;
    if (u >= 16'd39 && u <= 16'd41) return 1'b1;
    if (u >= 16'd44 && u <= 16'd46) return 1'b1;
    if (u >= 16'd48 && u <= 16'd58) return 1'b1;
    if (u == 16'd63) return 1'b1;
    if (u >= 16'd65 && u <= 16'd90) return 1'b1;
    return (u >= 16'd97 && u <= 16'd122);
  endfunction

  function automatic void push_sextet(input logic [5:0] v);
    item_bytes.push_back(Base64Alphabet[v]);
  endfunction

  function automatic void start_sextets(input logic [15:0] u);
    push_sextet(u[15:10]);
    push_sextet(u[9:4]);
    held_bits = {u[3:0], 2'b00};
    held_count = FourBitsHeld;
  endfunction

  function automatic void encode_unit16(input logic [15:0] u);
    if (shifted) begin
      if (is_direct(u)) begin
        if (held_count != NoBitsHeld) push_sextet(held_bits);
        item_bytes.push_back(AsciiMinus);
        item_bytes.push_back(u[7:0]);
        shifted = 1'b0;
      end else if (held_count == TwoBitsHeld) begin
        push_sextet(held_bits | {2'b00, u[15:12]});
        push_sextet(u[11:6]);
        push_sextet(u[5:0]);
        held_count = NoBitsHeld;
      end else if (held_count == FourBitsHeld) begin
        push_sextet(held_bits | {4'b0000, u[15:14]});
        push_sextet(u[13:8]);
        push_sextet(u[7:2]);
        held_bits = {u[1:0], 4'b0000};
        held_count = TwoBitsHeld;
      end else begin
        start_sextets(u);
      end
    end else if (is_direct(u)) begin
      item_bytes.push_back(u[7:0]);
    end else if (u == {8'h00, AsciiPlus}) begin
      item_bytes.push_back(AsciiPlus);
      item_bytes.push_back(AsciiMinus);
    end else begin
      item_bytes.push_back(AsciiPlus);
      start_sextets(u);
      shifted = 1'b1;
    end
  endfunction

  // Appends the beats that one accepted input item should produce.
  function automatic void predict_item(input utf7e_in_t item);
    logic [20:0] offset;
    utf7e_out_t  beat;
    item_bytes.delete();
    if (item.command == CmdEncode && item.code_point > LastScalar) begin
      beat.out_byte = 8'h00;
      beat.last = 1'b1;
      beat.error = 1'b1;
      expected_bytes.push_back(beat);
    end else begin
      if (item.command == CmdEnd) begin
        if (shifted) begin
          if (held_count != NoBitsHeld) push_sextet(held_bits);
          item_bytes.push_back(AsciiMinus);
          shifted = 1'b0;
        end
      end else if (item.code_point > LastBmp) begin
        offset = item.code_point - PlaneOne;
        encode_unit16({HighSurrogateTag, offset[19:10]});
        encode_unit16({LowSurrogateTag, offset[9:0]});
      end else begin
        encode_unit16(item.code_point[15:0]);
      end
      foreach (item_bytes[k]) begin
        beat.out_byte = item_bytes[k];
        beat.last = (k == item_bytes.size() - 1);
        beat.error = 1'b0;
        expected_bytes.push_back(beat);
      end
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    utf7e_out_t want;
    if (!rst_ni) begin
      shifted = 1'b0;
      held_count = NoBitsHeld;
      held_bits = '0;
      expected_bytes.delete();
      fails = 0;
      fail_count_o <= 0;
      pending_o <= 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_bytes.size() == 0) begin
          $error("unexpected beat: out_byte %h last %b error %b",
                 out_data_i.out_byte, out_data_i.last, out_data_i.error);
          fails++;
        end else begin
          want = expected_bytes.pop_front();
          if (out_data_i.out_byte !== want.out_byte) begin
            $error("out_byte: expected %h, got %h", want.out_byte, out_data_i.out_byte);
            fails++;
          end
          if (out_data_i.last !== want.last) begin
            $error("last: expected %b, got %b", want.last, out_data_i.last);
            fails++;
          end
          if (out_data_i.error !== want.error) begin
            $error("error: expected %b, got %b", want.error, out_data_i.error);
            fails++;
          end
        end
      end
      if (in_valid_i && !in_stall_i) predict_item(in_data_i);
      fail_count_o <= fails;
      pending_o <= expected_bytes.size();
    end
  end

endmodule

// ===== dv/tb_utf7_encoder.sv =====
`timescale 1ns / 100ps
// Testbench top for utf7_encoder: clock, reset, code point stimulus with random
// gaps and output stalls, and the verdict. Depends on utf7e_pkg, utf7_encoder
// and utf7_checker.
module tb_utf7_encoder;
  import utf7e_pkg::*;

  localparam int IdleLimit   = 2000;
  localparam int RandomItems = 92;

  logic       clk_i       = 1'b0;
  logic       rst_ni      = 1'b0;
  logic       in_valid_i  = 1'b0;
  utf7e_in_t  in_data_i   = '0;
  logic       out_stall_i = 1'b0;
  logic       in_stall_o;
  logic       out_valid_o;
  utf7e_out_t out_data_o;

  int   fail_count;
  int   pending;
  logic calm = 1'b0;
  int   stall_left = 0;

  wire in_beat  = in_valid_i && !in_stall_o;
  wire out_beat = out_valid_o && !out_stall_i;

  always #5 clk_i = ~clk_i;

  utf7_encoder dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  utf7_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_i   (in_stall_o),
    .in_data_i    (in_data_i),
    .out_valid_i  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .out_data_i   (out_data_o),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  // Output side: after each accepted beat, stall the output at random.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_beat) begin
        stall_left = calm ? 0 : $urandom_range(0, 13);
        out_stall_i <= (stall_left != 0);
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall_i <= (stall_left != 0);
      end
    end
  end

  // Called at a rising edge; returns at the edge where the beat is accepted.
  task automatic send_item(input logic cmd, input logic [20:0] cp);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 13);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= '{command: cmd, code_point: cp};
    do @(posedge clk_i); while (in_stall_o);
  endtask

  initial begin : stimulus
    string       direct_set;
    int          sent;
    int          kind;
    int          run_len;
    logic        cmd;
    logic [20:0] cp;
    direct_set = {"\t\n\r '(),-.0123456789:?",
                  "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz"};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: walks the shift state through every held-bit count.
    send_item(CmdEncode, 21'h000041);
    send_item(CmdEncode, 21'h00002B);
    send_item(CmdEncode, 21'h000009);
    send_item(CmdEncode, 21'h00007A);
    send_item(CmdEncode, 21'h000000);
    send_item(CmdEncode, 21'h00FFFF);
    send_item(CmdEncode, 21'h00002B);
    send_item(CmdEncode, 21'h0020AC);
    send_item(CmdEncode, 21'h00002E);
    send_item(CmdEnd,    21'h000000);
    send_item(CmdEncode, 21'h10FFFF);
    send_item(CmdEncode, 21'h110000);
    send_item(CmdEnd,    21'h1FFFFF);
    send_item(CmdEncode, 21'h010000);
    send_item(CmdEncode, 21'h00D800);
    send_item(CmdEncode, 21'h00003F);
    send_item(CmdEncode, 21'h00DFFF);
    send_item(CmdEncode, 21'h00007E);
    send_item(CmdEncode, 21'h00007F);
    send_item(CmdEnd,    21'h0AAAAA);
    send_item(CmdEncode, 21'h1FFFFF);
    send_item(CmdEncode, 21'h00000A);
    send_item(CmdEncode, 21'h00000D);
    send_item(CmdEncode, 21'h000020);
    send_item(CmdEncode, 21'h00003A);

    // Random part: short runs of one kind so the carry reaches every phase.
    sent = 0;
    while (sent < RandomItems) begin
      if ($urandom_range(0, 7) == 0) calm <= ~calm;
      kind = $urandom_range(0, 9);
      run_len = $urandom_range(1, 5);
      repeat (run_len) begin
        cmd = CmdEncode;
        case (kind)
          0, 1: cp = 21'(direct_set[$urandom_range(0, direct_set.len() - 1)]);
          2: cp = 21'h00002B;
          3: cp = 21'($urandom_range(0, 127));
          4, 5: cp = 21'($urandom_range(0, 21'h00FFFF));
          6, 7: cp = 21'($urandom_range(21'h010000, 21'h10FFFF));
          8: cp = 21'($urandom_range(21'h00D800, 21'h00DFFF));
          default: begin
            cp = 21'($urandom_range(21'h110000, 21'h1FFFFF));
            if ($urandom_range(0, 1) == 0) begin
              cmd = CmdEnd;
              cp = 21'($urandom_range(0, 21'h1FFFFF));
            end
          end
        endcase
        send_item(cmd, cp);
        sent++;
      end
      if ($urandom_range(0, 3) == 0) begin
        send_item(CmdEnd, 21'($urandom_range(0, 21'h1FFFFF)));
        sent++;
      end
    end
    send_item(CmdEnd, 21'h000000);

    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (4) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  initial begin : watchdog
    int idle;
    idle = 0;
    while (idle < IdleLimit) begin
      @(posedge clk_i);
      if (in_beat || out_beat) idle = 0;
      else idle++;
    end
    $display("status: fail");
    $finish;
  end

endmodule

// ===== sim.f =====
src/utf7e_pkg.sv
src/utf7e_encode.sv
src/utf7e_obuf.sv
src/utf7_encoder.sv
dv/utf7_checker.sv
dv/tb_utf7_encoder.sv
